### rtl/stbs_pkg.sv
// Shared widths, codes and sequencer states for the sorted table bracket search.
// No dependencies; imported by every module of the block.
package stbs_pkg;

   // Table and field widths
   localparam int STBS_TABLE_DEPTH = 1024;
   localparam int DATA_W           = 32;
   localparam int ENTRY_INDEX_W    = 10;
   localparam int COUNT_W          = 11;
   localparam int RESULT_INDEX_W   = 11;
   localparam int STATUS_W         = 2;
   localparam int NEARER_W         = 2;

   // Input operations
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BETWEEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BELOW   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABOVE   = 2'd3;

   // Nearer neighbor codes
   localparam logic [NEARER_W-1:0] NEARER_LOWER = 2'd0;
   localparam logic [NEARER_W-1:0] NEARER_UPPER = 2'd1;
   localparam logic [NEARER_W-1:0] NEARER_TIE   = 2'd2;

   // Search sequencer
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PROBE  = 4'b0010,
      ST_DIST   = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage

### rtl/stbs_table.sv
// Table storage for the bracket search: one write port, one registered read port.
// Depends on stbs_pkg for the data width.
module stbs_table
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = STBS_TABLE_DEPTH,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [TABLE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sorted_table_bracket_search.sv
// Sorted table bracket search: binary search over a loaded ascending table.
// Write beat: taken while idle, no result. Search beat: an accept step, then the
// probes (at most ceil(log2(count+1)) probes, 11 for 1024 entries), a distance
// step when the key is bracketed and a result step; probes share the single table read port.
// One beat at a time: req_stall is low only while the sequencer idles.
// Synchronous reset sets entry_count to 1; table contents stay undefined until written.
module sorted_table_bracket_search
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = STBS_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic        [ENTRY_INDEX_W-1:0]  req_entry_index,
   input  logic signed [DATA_W-1:0]         req_entry_value,
   input  logic signed [DATA_W-1:0]         req_search_key,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic        [STATUS_W-1:0]       rsp_status,
   output logic signed [RESULT_INDEX_W-1:0] rsp_lower_index,
   output logic        [RESULT_INDEX_W-1:0] rsp_upper_index,
   output logic        [NEARER_W-1:0]       rsp_nearer_side,
   // configuration
   input  logic                             csr_write_en,
   input  logic        [COUNT_W-1:0]        csr_write_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   // search bounds range from -1 up to the count
   localparam int BND_W  = ADDR_W + 2;
   localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] csr_count_ff;

   logic signed [BND_W-1:0] lo_ff, lo_in;
   logic signed [BND_W-1:0] hi_ff, hi_in;
   logic signed [BND_W-1:0] mid_ff, mid_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] probe_last_ff, probe_last_in;
   logic                     last_gt_ff, last_gt_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [NEARER_W-1:0]      nearer_ff, nearer_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]              rsp_status_ff;
   logic signed [RESULT_INDEX_W-1:0] rsp_lower_ff;
   logic [RESULT_INDEX_W-1:0]        rsp_upper_ff;
   logic [NEARER_W-1:0]              rsp_nearer_ff;

   logic                     req_take;
   logic                     rsp_load;
   logic [31:0]              cnt_32;
   logic signed [BND_W-1:0]  count_c;
   logic                     wr_en;
   logic [ADDR_W+ENTRY_INDEX_W-1:0] wr_idx_ext;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] probe;
   logic                     probe_gt, probe_lt;
   logic signed [BND_W-1:0]  nlo, nhi, init_hi;
   logic signed [DATA_W:0]   t_sum, key_x2;
   logic signed [DATA_W-1:0] t_other;
   logic signed [BND_W+RESULT_INDEX_W-1:0] hi_ext, lo_ext;

   // ---------------------------------------------------------------
   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= COUNT_W'(1);
      end else if (csr_write_en) begin
         csr_count_ff <= csr_write_data;
      end
   end

   // Count in use: zero reads as one, saturated at the table depth
   always_comb begin
      cnt_32 = 32'(csr_count_ff);
      if (cnt_32 == 32'd0) begin
         count_c = BND_W'(1);
      end else if (cnt_32 > DEPTH_32) begin
         count_c = BND_W'(TABLE_DEPTH);
      end else begin
         count_c = BND_W'(csr_count_ff);
      end
   end

   // ---------------------------------------------------------------
   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // Table write from a write beat; indices past the depth are dropped
   assign wr_idx_ext = {{ADDR_W{1'b0}}, req_entry_index};
   assign wr_en = req_take && (req_op == OP_WRITE) &&
                  (32'(req_entry_index) < DEPTH_32);

   stbs_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ext[ADDR_W-1:0]),
      .wr_data (req_entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // Probe compare and next bounds
   assign probe    = $signed(rd_data);
   assign probe_gt = probe > key_ff;
   assign probe_lt = probe < key_ff;
   assign nlo      = probe_lt ? (mid_ff + BND_W'(1)) : lo_ff;
   assign nhi      = probe_gt ? (mid_ff - BND_W'(1)) : hi_ff;
   assign init_hi  = count_c - BND_W'(1);

   // Distance compare: key - t_hi versus t_lo - key, as 2*key versus the sum
   assign t_other = probe;
   assign t_sum   = last_gt_ff ? (DATA_W+1)'(probe_last_ff) + (DATA_W+1)'(t_other)
                               : (DATA_W+1)'(t_other) + (DATA_W+1)'(probe_last_ff);
   assign key_x2  = (DATA_W+1)'(key_ff) <<< 1;

   // ---------------------------------------------------------------
   // Sequencer
   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      probe_last_in = probe_last_ff;
      last_gt_in    = last_gt_ff;
      status_in     = status_ff;
      nearer_in     = nearer_ff;
      rd_addr       = mid_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            // first probe at the middle of the full range
            lo_in   = '0;
            hi_in   = init_hi;
            mid_in  = init_hi >>> 1;
            rd_addr = mid_in[ADDR_W-1:0];
            key_in  = req_search_key;
            if (req_take && (req_op == OP_SEARCH)) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            probe_last_in = probe;
            last_gt_in    = probe_gt;
            nearer_in     = NEARER_LOWER;
            if (!probe_gt && !probe_lt) begin
               // match
               lo_in     = mid_ff;
               hi_in     = mid_ff;
               status_in = STATUS_FOUND;
               state_in  = ST_RESULT;
            end else begin
               lo_in = nlo;
               hi_in = nhi;
               if (nlo <= nhi) begin
                  mid_in   = (nlo + nhi) >>> 1;
                  rd_addr  = mid_in[ADDR_W-1:0];
               end else if (nhi < 0) begin
                  status_in = STATUS_BELOW;
                  state_in  = ST_RESULT;
               end else if (nlo > init_hi) begin
                  status_in = STATUS_ABOVE;
                  state_in  = ST_RESULT;
               end else begin
                  // bracketed: the last probe is one neighbor, fetch the other
                  status_in = STATUS_BETWEEN;
                  rd_addr   = probe_gt ? nhi[ADDR_W-1:0] : nlo[ADDR_W-1:0];
                  state_in  = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            if (key_x2 < t_sum) begin
               nearer_in = NEARER_LOWER;
            end else if (key_x2 > t_sum) begin
               nearer_in = NEARER_UPPER;
            end else begin
               nearer_in = NEARER_TIE;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search datapath registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      probe_last_ff <= probe_last_in;
      last_gt_ff    <= last_gt_in;
      status_ff     <= status_in;
      nearer_ff     <= nearer_in;
   end

   // ---------------------------------------------------------------
   // Output register: lower index carries the upper bound and vice versa
   assign hi_ext = (BND_W+RESULT_INDEX_W)'(hi_ff);
   assign lo_ext = (BND_W+RESULT_INDEX_W)'(lo_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_lower_ff  <= hi_ext[RESULT_INDEX_W-1:0];
         rsp_upper_ff  <= lo_ext[RESULT_INDEX_W-1:0];
         rsp_nearer_ff <= (status_ff == STATUS_BETWEEN) ? nearer_ff : NEARER_LOWER;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_lower_index = rsp_lower_ff;
   assign rsp_upper_index = rsp_upper_ff;
   assign rsp_nearer_side = rsp_nearer_ff;

endmodule

### tb/sv/tb_sorted_table_bracket_search.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_table_bracket_search: random beats, stalls, checks.
// Depends on rtl/stbs_pkg.sv, rtl/stbs_table.sv and rtl/sorted_table_bracket_search.sv.
module tb_sorted_table_bracket_search;
   import stbs_pkg::*;

   localparam int     HALF_PERIOD    = 5;
   localparam int     IDLE_PCT       = 33;
   localparam int     SETTLE_CYCLES  = 20;
   localparam int     WATCHDOG_LIMIT = 3000;
   localparam longint KEY_MIN        = -64'sd2147483648;
   localparam longint KEY_MAX        = 64'sd2147483647;

   typedef struct packed {
      logic                      op;
      logic [ENTRY_INDEX_W-1:0]  entry_index;
      logic [DATA_W-1:0]         entry_value;
      logic [DATA_W-1:0]         search_key;
   } table_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [RESULT_INDEX_W-1:0] lower_index;
      logic [RESULT_INDEX_W-1:0] upper_index;
      logic [NEARER_W-1:0]       nearer_side;
   } bracket_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_op = OP_WRITE;
   logic        [ENTRY_INDEX_W-1:0]  req_entry_index = '0;
   logic signed [DATA_W-1:0]         req_entry_value = '0;
   logic signed [DATA_W-1:0]         req_search_key = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic        [STATUS_W-1:0]       rsp_status;
   logic signed [RESULT_INDEX_W-1:0] rsp_lower_index;
   logic        [RESULT_INDEX_W-1:0] rsp_upper_index;
   logic        [NEARER_W-1:0]       rsp_nearer_side;
   logic                             csr_write_en = 1'b0;
   logic        [COUNT_W-1:0]        csr_write_data = '0;

   // Beats waiting for the driver, brackets waiting for the DUT
   table_request_type  request_fifo[$];
   bracket_result_type bracket_fifo[$];

   // Shadow of the DUT: table contents as seen at accepted beats, entry count at CSR writes
   logic signed [DATA_W-1:0] model_table [STBS_TABLE_DEPTH];
   logic        [COUNT_W-1:0] model_count = COUNT_W'(1);

   // Generator's own view of what it loaded, used only to aim keys
   longint gen_table [STBS_TABLE_DEPTH];
   // Indices loaded on the outermost probe paths of the full table
   int     spine_idx[$];

   logic req_taken = 1'b0;
   bit   steady_flow = 1'b0;
   int   queued_beats = 0;
   int   accepted_beats = 0;
   int   idle_cycles = 0;
   int   fail_count = 0;
   int   writes_seen = 0;
   int   searches_checked = 0;
   int   count_settings = 0;
   int   status_tally [4] = '{0, 0, 0, 0};
   int   tie_tally = 0;

   sorted_table_bracket_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_lower_index (rsp_lower_index),
      .rsp_upper_index (rsp_upper_index),
      .rsp_nearer_side (rsp_nearer_side),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Binary search over the shadow table; bounds come out swapped as the port names say
   function automatic bracket_result_type predict_bracket(input logic signed [DATA_W-1:0] key);
      int                 span, lo, hi, mid;
      longint             d_low, d_up;
      bit                 hit;
      bracket_result_type r;
      span = int'(model_count);
      if (span < 1) span = 1;
      if (span > STBS_TABLE_DEPTH) span = STBS_TABLE_DEPTH;
      lo  = 0;
      hi  = span - 1;
      mid = 0;
      hit = 1'b0;
      while (!hit && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (model_table[mid] > key) hi = mid - 1;
         else if (model_table[mid] < key) lo = mid + 1;
         else hit = 1'b1;
      end
      r.nearer_side = NEARER_LOWER;
      if (hit) begin
         r.status = STATUS_FOUND;
         lo = mid;
         hi = mid;
      end else if (hi >= 0 && lo <= span - 1) begin
         // distances at full width, no wrap
         d_low = longint'(key) - longint'(model_table[hi]);
         d_up  = longint'(model_table[lo]) - longint'(key);
         r.status = STATUS_BETWEEN;
         if (d_low < d_up) r.nearer_side = NEARER_LOWER;
         else if (d_low > d_up) r.nearer_side = NEARER_UPPER;
         else r.nearer_side = NEARER_TIE;
      end else if (hi < 0) begin
         r.status = STATUS_BELOW;
      end else begin
         r.status = STATUS_ABOVE;
      end
      r.lower_index = hi[RESULT_INDEX_W-1:0];
      r.upper_index = lo[RESULT_INDEX_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string field_name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, exp_v, got_v);
         fail_count++;
      end
   endtask

   function automatic longint rand_below(input longint lim);
      return longint'({$urandom, $urandom} % lim);
   endfunction

   task automatic queue_write(input int idx, input longint val);
      table_request_type beat;
      beat.op          = OP_WRITE;
      beat.entry_index = idx[ENTRY_INDEX_W-1:0];
      beat.entry_value = val[DATA_W-1:0];
      beat.search_key  = $urandom;
      gen_table[idx]   = val;
      request_fifo.push_back(beat);
      queued_beats++;
   endtask

   task automatic queue_search(input longint key);
      table_request_type beat;
      beat.op          = OP_SEARCH;
      beat.entry_index = ENTRY_INDEX_W'($urandom_range(0, STBS_TABLE_DEPTH - 1));
      beat.entry_value = $urandom;
      beat.search_key  = key[DATA_W-1:0];
      request_fifo.push_back(beat);
      queued_beats++;
   endtask

   // Key aimed at a hit, a gap, a midpoint, either end, an extreme or anywhere
   function automatic longint pick_key(input int span);
      longint a, b, k, first, last;
      int     i;
      k     = KEY_MIN + rand_below(64'h1_0000_0000);
      first = gen_table[0];
      last  = gen_table[span-1];
      a     = first;
      b     = first;
      if (span > 1) begin
         i = $urandom_range(0, span - 2);
         a = gen_table[i];
         b = gen_table[i+1];
      end
      case ($urandom_range(0, 9))
         0, 1, 2: k = gen_table[$urandom_range(0, span - 1)];
         3, 4:    if (b > a + 1) k = a + 1 + rand_below(b - a - 1);
         5:       if ((a + b) % 2 == 0) k = (a + b) / 2;
         6:       if (first > KEY_MIN) k = first - 1 - rand_below(first - KEY_MIN);
         7:       if (last < KEY_MAX) k = last + 1 + rand_below(KEY_MAX - last);
         8:       k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
         default: ;
      endcase
      return k;
   endfunction

   // Well-formed load: entries 0..n-1 in nondecreasing order
   task automatic fill_ascending(input int n, input longint base, input longint step_max);
      longint v;
      int     i;
      v = base;
      for (i = 0; i < n; i++) begin
         queue_write(i, v);
         v += rand_below(step_max + 1);
         if (v > KEY_MAX) v = KEY_MAX;
      end
   endtask

   // Mostly searches, with a few stray writes that can break the ordering
   task automatic run_searches(input int span, input int n);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8)
            queue_write($urandom_range(0, span - 1), KEY_MIN + rand_below(64'h1_0000_0000));
         else
            queue_search(pick_key(span));
      end
   endtask

   // Full-depth load of only the entries on the leftmost and rightmost probe paths,
   // ascending with index at an even spacing
   task automatic fill_spine(input longint step);
      int lo, hi, mid, side;
      for (side = 0; side < 2; side++) begin
         lo = 0;
         hi = STBS_TABLE_DEPTH - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            queue_write(mid, KEY_MIN / 2 + longint'(mid) * step);
            spine_idx.push_back(mid);
            if (side == 0) hi = mid - 1;
            else lo = mid + 1;
         end
      end
   endtask

   // Keys whose probes stay on the loaded paths: hits, both ends, outermost gaps, ties
   task automatic spine_searches(input longint step, input int n);
      longint a, b, key;
      int     k, last_idx;
      last_idx = STBS_TABLE_DEPTH - 1;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 1) == 0) begin
            a = gen_table[0];
            b = gen_table[1];
         end else begin
            a = gen_table[last_idx - 1];
            b = gen_table[last_idx];
         end
         case ($urandom_range(0, 6))
            0, 1, 2: key = gen_table[spine_idx[$urandom_range(0, spine_idx.size() - 1)]];
            3:       key = gen_table[0] - 1 - rand_below(gen_table[0] - KEY_MIN);
            4:       key = gen_table[last_idx] + 1 + rand_below(KEY_MAX - gen_table[last_idx]);
            5:       key = a + 1 + rand_below(b - a - 1);
            default: key = a + step / 2;
         endcase
         queue_search(key);
      end
   endtask

   task automatic wait_idle();
      while (accepted_beats != queued_beats || bracket_fifo.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_entry_count(input int value);
      wait_idle();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= COUNT_W'(value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
      count_settings++;
   endtask

   // Request driver: next beat only once the current one has gone
   always @(negedge clock) begin : drive_requests
      table_request_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_fifo.size() != 0 && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
            beat = request_fifo.pop_front();
            req_op          <= beat.op;
            req_entry_index <= beat.entry_index;
            req_entry_value <= beat.entry_value;
            req_search_key  <= beat.search_key;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Monitor: update the shadow on accepted beats, check every result beat
   always @(posedge clock) begin : check_results
      bracket_result_type want;
      bit                 moved;
      req_taken <= !reset && req_valid && !req_stall;
      moved = 1'b0;
      if (reset) begin
         model_count = COUNT_W'(1);
         bracket_fifo.delete();
         idle_cycles = 0;
      end else begin
         if (csr_write_en) begin
            model_count = csr_write_data;
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            accepted_beats++;
            moved = 1'b1;
            if (req_op == OP_WRITE) begin
               model_table[req_entry_index] = req_entry_value;
               writes_seen++;
            end else begin
               bracket_fifo.push_back(predict_bracket(req_search_key));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (bracket_fifo.size() == 0) begin
               $display("%0t: result beat with nothing expected, status %0d lower %0d upper %0d",
                        $time, rsp_status, rsp_lower_index, rsp_upper_index);
               fail_count++;
            end else begin
               want = bracket_fifo.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("lower_index", $signed(want.lower_index), rsp_lower_index);
               check_field("upper_index", want.upper_index, rsp_upper_index);
               check_field("nearer_side", want.nearer_side, rsp_nearer_side);
               searches_checked++;
               status_tally[want.status]++;
               if (want.status == STATUS_BETWEEN && want.nearer_side == NEARER_TIE) tie_tally++;
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, bracket_fifo.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int     p, cnt;
      longint step_max;
      longint spine_step;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset count of one: hit, below, above, extreme index and values
      queue_write(0, 0);
      queue_search(0);
      queue_search(-5);
      queue_search(7);
      queue_write(STBS_TABLE_DEPTH - 1, KEY_MAX);
      queue_write(0, KEY_MIN);
      queue_search(KEY_MAX);

      // Three entries: lower nearer, upper nearer, tie, both ends
      load_entry_count(3);
      queue_write(0, -100);
      queue_write(1, 0);
      queue_write(2, 100);
      queue_search(-60);
      queue_search(-40);
      queue_search(-50);
      queue_search(-101);
      queue_search(101);
      // full-range neighbors, distances beyond 32 bits
      queue_write(0, KEY_MIN);
      queue_write(2, KEY_MAX);
      queue_search(-1);
      queue_search(KEY_MIN);
      queue_write(1, KEY_MAX);
      queue_search(0);

      // Small tables with random content and spacing
      for (p = 0; p < 7; p++) begin
         cnt = (p == 0) ? 2 : $urandom_range(1, 48);
         load_entry_count(cnt);
         steady_flow = (p == 3);
         case ($urandom_range(0, 2))
            0:       step_max = 4;
            1:       step_max = 2000;
            default: step_max = 64'd1 << 26;
         endcase
         fill_ascending(cnt, KEY_MIN + rand_below(64'h1_0000_0000), step_max);
         run_searches(cnt, 45);
      end

      // Full-depth count over the outermost probe paths, then counts above the depth
      load_entry_count(STBS_TABLE_DEPTH);
      spine_step = 2 * (1 + rand_below(64'd1 << 20));
      fill_spine(spine_step);
      spine_searches(spine_step, 60);
      load_entry_count(11'd2047);
      spine_searches(spine_step, 25);
      load_entry_count(STBS_TABLE_DEPTH + 1);
      spine_searches(spine_step, 15);
      // count of zero
      load_entry_count(0);
      run_searches(1, 20);

      wait_idle();
      $display("Checked %0d searches (found %0d, between %0d with %0d ties, below %0d, above %0d)",
               searches_checked, status_tally[STATUS_FOUND], status_tally[STATUS_BETWEEN],
               tie_tally, status_tally[STATUS_BELOW], status_tally[STATUS_ABOVE]);
      $display("after %0d table writes over %0d entry_count settings, %0d mismatches",
               writes_seen, count_settings, fail_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
